// ----- hw/rtl/tcp_byte_stream_reassembler_macros.svh -----
// Assertion macros shared by the reassembler RTL.
`ifndef TCP_BYTE_STREAM_REASSEMBLER_MACROS_SVH
`define TCP_BYTE_STREAM_REASSEMBLER_MACROS_SVH

// Checks a consequence in the same cycle as its condition.
`define TBSR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks a consequence in the cycle after its condition.
`define TBSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/tbsr_pkg.sv -----
package tbsr_pkg;

    // Field widths of the stream channels.
    localparam int FUNC_W     = 2;
    localparam int INDEX_W    = 64;
    localparam int BYTE_W     = 8;
    localparam int CONSUMED_W = 7;
    localparam int HELD_OUT_W = 7;

    // Packed channel widths, padded to whole bytes.
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 80;

    // Default window size in bytes.
    localparam int CAPACITY_DEFAULT = 64;

    // Request kinds carried on the input tuser.
    localparam logic [FUNC_W-1:0] FUNC_DATA    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_END     = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CONSUME = 2'd2;

    // Sequencer states, one-hot.
    typedef enum logic [9:0] {
        S_CLEAR   = 10'b00_0000_0001,
        S_IDLE    = 10'b00_0000_0010,
        S_EVAL    = 10'b00_0000_0100,
        S_SLOT    = 10'b00_0000_1000,
        S_CHECK   = 10'b00_0001_0000,
        S_SCAN_RD = 10'b00_0010_0000,
        S_SCAN_TS = 10'b00_0100_0000,
        S_STATUS  = 10'b00_1000_0000,
        S_EMIT_RD = 10'b01_0000_0000,
        S_LOAD    = 10'b10_0000_0000
    } state_t;

endpackage

// ----- hw/rtl/tcp_byte_stream_reassembler.sv -----
// Sequence: a data request passes EVAL, SLOT and CHECK, then scans the window slot by slot
// (SCAN_RD, SCAN_TS), updates STATUS and loads each delivered byte (EMIT_RD, LOAD), or one
// empty result; end marks and consume requests skip SLOT and CHECK, and output stalls hold
// LOAD. One request at a time: the input is ready only in IDLE. The shared 64-bit adder
// serves EVAL, CHECK and STATUS. Reset: asynchronous, active low, then a clear of every
// slot flag.
`include "tcp_byte_stream_reassembler_macros.svh"

module tcp_byte_stream_reassembler #(
    parameter int CAPACITY = tbsr_pkg::CAPACITY_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // tdata from bit 0: stream_index[63:0], byte_value[71:64], consumed_count[78:72], zero
    input  logic [tbsr_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: func
    input  logic [tbsr_pkg::FUNC_W-1:0]    s_axis_tuser,
    // tlast: ends_stream
    input  logic                           s_axis_tlast,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata from bit 0: out_byte[7:0], stream_ended[8], unassembled_count[15:9],
    // next_expected[79:16]
    output logic [tbsr_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // tuser: out_valid
    output logic                           m_axis_tuser,
    // tlast: last
    output logic                           m_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready
);

    import tbsr_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > CONSUMED_W) ? CNT_W : CONSUMED_W;
    localparam logic [IDX_W:0]   CAP_S = (IDX_W + 1)'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(CAPACITY - 1);

    // Reduces a sum of two slot numbers back into the ring.
    function automatic logic [IDX_W-1:0] wrap_slot(input logic [IDX_W:0] s);
        logic [IDX_W:0] t;
        t = s - CAP_S;
        return (s >= CAP_S) ? t[IDX_W-1:0] : s[IDX_W-1:0];
    endfunction

    // Control registers.
    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [INDEX_W-1:0] next_index_reg, next_index_next;
    logic [CNT_W-1:0]  buffered_reg, buffered_next;
    logic [CNT_W-1:0]  held_reg, held_next;
    logic              end_seen_reg, end_seen_next;
    logic [INDEX_W-1:0] end_index_reg, end_index_next;
    logic [CNT_W-1:0]  run_reg, run_next;
    logic [CNT_W-1:0]  emit_cnt_reg, emit_cnt_next;
    logic              m_valid_reg, m_valid_next;

    // Payload registers.
    logic [FUNC_W-1:0]     func_reg;
    logic [INDEX_W-1:0]    idx_reg;
    logic [BYTE_W-1:0]     val_reg;
    logic                  eos_reg;
    logic [CONSUMED_W-1:0] used_reg;
    logic [INDEX_W-1:0]    diff_reg;
    logic                  ge_reg;
    logic                  win_reg;
    logic [IDX_W-1:0]      slot_reg;
    logic                  present_rd_reg;
    logic [BYTE_W-1:0]     byte_rd_reg;
    logic                  out_user_reg;
    logic [BYTE_W-1:0]     out_byte_reg;
    logic                  out_last_reg;
    logic                  out_ended_reg;
    logic [HELD_OUT_W-1:0] out_held_reg;
    logic [INDEX_W-1:0]    out_next_reg;

    // Slot storage.
    logic              present_mem [CAPACITY];
    logic [BYTE_W-1:0] byte_mem [CAPACITY];

    logic              pm_we;
    logic [IDX_W-1:0]  pm_waddr;
    logic              pm_wdata;
    logic              pm_re;
    logic [IDX_W-1:0]  pm_raddr;
    logic              bm_we;
    logic              bm_re;

    // Shared adder.
    logic [INDEX_W-1:0] add_a;
    logic [INDEX_W-1:0] add_b;
    logic               add_cin;
    logic [INDEX_W:0]   add_sum;

    logic              accept_in;
    logic              load_fire;
    logic              in_window;
    logic [CNT_W-1:0]  room;
    logic [IDX_W-1:0]  slot_calc;
    logic [IDX_W-1:0]  scan_slot;
    logic [CNT_W-1:0]  run_inc;
    logic [CNT_W-1:0]  emit_inc;
    logic              load_last;
    logic [CMP_W-1:0]  used_x;
    logic [CMP_W-1:0]  buf_x;
    logic [CMP_W-1:0]  buf_left;

    assign accept_in     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign load_fire     = (state_reg == S_LOAD) && (!m_valid_reg || m_axis_tready);

    // Window test and ring position of the incoming byte.
    assign room      = CAP_C - buffered_reg;
    assign in_window = ge_reg && (diff_reg[INDEX_W-1:CNT_W] == '0)
                       && (diff_reg[CNT_W-1:0] < room);
    assign slot_calc = wrap_slot({1'b0, head_reg} + {1'b0, diff_reg[IDX_W-1:0]});
    assign scan_slot = wrap_slot({1'b0, head_reg} + {1'b0, run_reg[IDX_W-1:0]});
    assign run_inc   = run_reg + 1'b1;
    assign emit_inc  = emit_cnt_reg + 1'b1;
    assign load_last = (run_reg == '0) || (emit_inc == run_reg);

    // Consume request: the output buffer count saturates at zero.
    assign used_x   = CMP_W'(used_reg);
    assign buf_x    = CMP_W'(buffered_reg);
    assign buf_left = buf_x - used_x;

    // Operand selection for the shared adder.
    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        case (state_reg)
            S_EVAL:
            begin
                add_a   = idx_reg;
                add_b   = ~next_index_reg;
                add_cin = 1'b1;
            end
            S_CHECK:
            begin
                add_a   = idx_reg;
                add_cin = 1'b1;
            end
            S_STATUS:
            begin
                add_a = next_index_reg;
                add_b = INDEX_W'(run_reg);
            end
            default:
            begin
                add_a   = '0;
            end
        endcase
    end

    assign add_sum = {1'b0, add_a} + {1'b0, add_b} + (INDEX_W + 1)'(add_cin);

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        head_next       = head_reg;
        next_index_next = next_index_reg;
        buffered_next   = buffered_reg;
        held_next       = held_reg;
        end_seen_next   = end_seen_reg;
        end_index_next  = end_index_reg;
        run_next        = run_reg;
        emit_cnt_next   = emit_cnt_reg;
        m_valid_next    = m_valid_reg;
        pm_we           = 1'b0;
        pm_waddr        = head_reg;
        pm_wdata        = 1'b0;
        pm_re           = 1'b0;
        pm_raddr        = scan_slot;
        bm_we           = 1'b0;
        bm_re           = 1'b0;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                pm_we    = 1'b1;
                pm_waddr = clr_cnt_reg;
                if (clr_cnt_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (accept_in)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                run_next   = '0;
                state_next = S_SCAN_RD;
                case (func_reg)
                    FUNC_DATA:
                    begin
                        state_next = S_SLOT;
                    end
                    FUNC_END:
                    begin
                        end_seen_next  = 1'b1;
                        end_index_next = idx_reg;
                    end
                    FUNC_CONSUME:
                    begin
                        buffered_next = (used_x >= buf_x) ? '0 : CNT_W'(buf_left);
                    end
                    default:
                    begin
                        state_next = S_SCAN_RD;
                    end
                endcase
            end
            S_SLOT:
            begin
                pm_re      = in_window;
                pm_raddr   = slot_calc;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (eos_reg)
                begin
                    end_seen_next  = 1'b1;
                    end_index_next = add_sum[INDEX_W-1:0];
                end
                if (win_reg && !present_rd_reg)
                begin
                    pm_we     = 1'b1;
                    pm_waddr  = slot_reg;
                    pm_wdata  = 1'b1;
                    bm_we     = 1'b1;
                    held_next = held_reg + 1'b1;
                end
                state_next = S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                pm_re      = 1'b1;
                pm_raddr   = scan_slot;
                state_next = S_SCAN_TS;
            end
            S_SCAN_TS:
            begin
                if (present_rd_reg)
                begin
                    run_next   = run_inc;
                    state_next = (run_inc == CAP_C) ? S_STATUS : S_SCAN_RD;
                end
                else
                begin
                    state_next = S_STATUS;
                end
            end
            S_STATUS:
            begin
                next_index_next = add_sum[INDEX_W-1:0];
                held_next       = held_reg - run_reg;
                buffered_next   = buffered_reg + run_reg;
                emit_cnt_next   = '0;
                state_next      = (run_reg == '0) ? S_LOAD : S_EMIT_RD;
            end
            S_EMIT_RD:
            begin
                bm_re      = 1'b1;
                pm_we      = 1'b1;
                pm_waddr   = head_reg;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (load_fire)
                begin
                    m_valid_next = 1'b1;
                    if (run_reg != '0)
                    begin
                        head_next     = wrap_slot({1'b0, head_reg} + (IDX_W + 1)'(1));
                        emit_cnt_next = emit_inc;
                    end
                    state_next = load_last ? S_IDLE : S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            head_reg       <= '0;
            next_index_reg <= '0;
            buffered_reg   <= '0;
            held_reg       <= '0;
            end_seen_reg   <= 1'b0;
            end_index_reg  <= '0;
            run_reg        <= '0;
            emit_cnt_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            head_reg       <= head_next;
            next_index_reg <= next_index_next;
            buffered_reg   <= buffered_next;
            held_reg       <= held_next;
            end_seen_reg   <= end_seen_next;
            end_index_reg  <= end_index_next;
            run_reg        <= run_next;
            emit_cnt_reg   <= emit_cnt_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Request capture and intermediate results.
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            func_reg <= s_axis_tuser;
            idx_reg  <= s_axis_tdata[INDEX_W-1:0];
            val_reg  <= s_axis_tdata[INDEX_W+BYTE_W-1:INDEX_W];
            eos_reg  <= s_axis_tlast;
            used_reg <= s_axis_tdata[INDEX_W+BYTE_W+CONSUMED_W-1:INDEX_W+BYTE_W];
        end
        if (state_reg == S_EVAL)
        begin
            diff_reg <= add_sum[INDEX_W-1:0];
            ge_reg   <= add_sum[INDEX_W];
        end
        if (state_reg == S_SLOT)
        begin
            win_reg  <= in_window;
            slot_reg <= slot_calc;
        end
    end

    // Slot flag memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (pm_we)
        begin
            present_mem[pm_waddr] <= pm_wdata;
        end
        if (pm_re)
        begin
            present_rd_reg <= present_mem[pm_raddr];
        end
        else if (state_reg == S_SLOT)
        begin
            present_rd_reg <= 1'b1;
        end
    end

    // Slot byte memory.
    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            byte_mem[slot_reg] <= val_reg;
        end
        if (bm_re)
        begin
            byte_rd_reg <= byte_mem[head_reg];
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (load_fire)
        begin
            out_user_reg  <= (run_reg != '0);
            out_byte_reg  <= (run_reg != '0) ? byte_rd_reg : '0;
            out_last_reg  <= load_last;
            out_ended_reg <= end_seen_reg && (next_index_reg == end_index_reg);
            out_held_reg  <= HELD_OUT_W'(held_reg);
            out_next_reg  <= next_index_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {out_next_reg, out_held_reg, out_ended_reg, out_byte_reg};

    // Checks on the window bookkeeping and the delivery sequence.
    `TBSR_ASSERT_SAME(a_window_bound, 1'b1,
        ({1'b0, held_reg} + {1'b0, buffered_reg}) <= {1'b0, CAP_C},
        "held and buffered bytes exceed the window")
    `TBSR_ASSERT_SAME(a_emit_in_run, (state_reg == S_EMIT_RD),
        (run_reg != '0) && (emit_cnt_reg < run_reg),
        "byte read beyond the contiguous run")
    `TBSR_ASSERT_NEXT(a_last_to_idle, load_fire && load_last,
        (state_reg == S_IDLE) && m_axis_tvalid && m_axis_tlast,
        "last result loaded without returning to idle")
    `TBSR_ASSERT_NEXT(a_accept_eval, accept_in,
        (state_reg == S_EVAL) && !s_axis_tready,
        "accepted request not evaluated")

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import tbsr_pkg::*;

    localparam int WINDOW = CAPACITY_DEFAULT;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE_CYCLES = 300;
    localparam int RANDOM_REQUESTS = 300;
    localparam int REPORT_LIMIT = 10;

    // One request as the sender sees it.
    typedef struct packed {
        logic [FUNC_W-1:0]     func;
        logic [INDEX_W-1:0]    index;
        logic [BYTE_W-1:0]     value;
        logic                  ends;
        logic [CONSUMED_W-1:0] consumed;
    } stream_req_t;

    // One delivered result, fields in the order they are unpacked from the bus.
    typedef struct packed {
        logic                  valid;
        logic [BYTE_W-1:0]     data;
        logic                  last;
        logic                  ended;
        logic [HELD_OUT_W-1:0] held;
        logic [INDEX_W-1:0]    next_exp;
    } delivery_t;

    // Tracks the reassembly window and the deliveries it must produce.
    class reassembly_scoreboard;
        logic [BYTE_W-1:0]  slot_data [WINDOW];
        bit                 slot_full [WINDOW];
        logic [INDEX_W-1:0] next_index;
        int unsigned        buffered_bytes;
        int unsigned        held_bytes;
        bit                 end_seen;
        logic [INDEX_W-1:0] end_index;
        int unsigned        head_slot;
        delivery_t          expected_deliveries[$];
        int                 mismatches;

        function new();
            foreach (slot_full[k])
            begin
                slot_full[k] = 1'b0;
                slot_data[k] = '0;
            end
            next_index = '0;
            buffered_bytes = 0;
            held_bytes = 0;
            end_seen = 1'b0;
            end_index = '0;
            head_slot = 0;
            mismatches = 0;
        endfunction

        function int unsigned window_room();
            return (buffered_bytes >= WINDOW) ? 0 : WINDOW - buffered_bytes;
        endfunction

        // Applies one accepted request and queues every result it causes.
        function void note_request(stream_req_t req);
            logic [INDEX_W-1:0] offset;
            int unsigned        slot;
            delivery_t          batch[$];
            delivery_t          d;

            case (req.func)
                FUNC_DATA:
                begin
                    // The end flag counts even when the byte itself is dropped.
                    if (req.ends)
                    begin
                        end_seen = 1'b1;
                        end_index = req.index + 64'd1;
                    end
                    offset = req.index - next_index;
                    if (req.index >= next_index && offset < window_room())
                    begin
                        slot = (head_slot + int'(offset)) % WINDOW;
                        if (!slot_full[slot])
                        begin
                            slot_full[slot] = 1'b1;
                            slot_data[slot] = req.value;
                            held_bytes++;
                        end
                    end
                end
                FUNC_END:
                begin
                    end_seen = 1'b1;
                    end_index = req.index;
                end
                FUNC_CONSUME:
                begin
                    buffered_bytes = (req.consumed >= buffered_bytes) ? 0
                                   : buffered_bytes - req.consumed;
                end
                default: ;
            endcase

            // Flush everything that is now contiguous with the head of the window.
            while (batch.size() < WINDOW && slot_full[head_slot])
            begin
                d = '0;
                d.valid = 1'b1;
                d.data = slot_data[head_slot];
                batch = {batch, d};
                slot_full[head_slot] = 1'b0;
                head_slot = (head_slot + 1) % WINDOW;
                next_index++;
                if (held_bytes > 0)
                    held_bytes--;
                buffered_bytes++;
            end
            if (batch.size() == 0)
            begin
                d = '0;
                batch = {batch, d};
            end

            // Status fields reflect the state after the whole request.
            foreach (batch[k])
            begin
                batch[k].last = (k == batch.size() - 1);
                batch[k].ended = end_seen && (next_index == end_index);
                batch[k].held = HELD_OUT_W'(held_bytes);
                batch[k].next_exp = next_index;
                expected_deliveries = {expected_deliveries, batch[k]};
            end
        endfunction

        function void log_mismatch(string what, delivery_t want, delivery_t got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
            begin
                $display("mismatch (%s): expected valid=%0b byte=%h last=%0b ended=%0b",
                         what, want.valid, want.data, want.last, want.ended);
                $display("    held=%0d next=%h; got valid=%0b byte=%h last=%0b ended=%0b",
                         want.held, want.next_exp, got.valid, got.data, got.last, got.ended);
                $display("    held=%0d next=%h", got.held, got.next_exp);
            end
        endfunction

        // Compares one accepted result with the oldest pending expectation.
        function void check_delivery(delivery_t got);
            delivery_t want;

            if (expected_deliveries.size() == 0)
            begin
                log_mismatch("no result pending", '0, got);
                return;
            end
            want = expected_deliveries[0];
            expected_deliveries.delete(0);
            if (got.valid !== want.valid || got.data !== want.data ||
                got.last !== want.last || got.ended !== want.ended ||
                got.held !== want.held || got.next_exp !== want.next_exp)
                log_mismatch("field differs", want, got);
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic [FUNC_W-1:0]      s_axis_tuser = FUNC_DATA;
    logic                   s_axis_tlast = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;

    reassembly_scoreboard   sb;
    int                     burst_left = 0;
    int                     rx_mode = 0;
    int                     rx_left = 0;
    int                     rx_tick = 0;
    int                     cycle_count = 0;

    tcp_byte_stream_reassembler #(
        .CAPACITY(WINDOW)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic stream_req_t make_req(logic [FUNC_W-1:0] func, logic [INDEX_W-1:0] index,
                                             logic [BYTE_W-1:0] value, logic ends,
                                             logic [CONSUMED_W-1:0] consumed);
        stream_req_t req;

        req.func = func;
        req.index = index;
        req.value = value;
        req.ends = ends;
        req.consumed = consumed;
        return req;
    endfunction

    // Offers one request, waits for acceptance and then maybe ends the burst.
    task automatic send_request(stream_req_t req);
        s_axis_tdata <= S_TDATA_W'({req.consumed, req.value, req.index});
        s_axis_tuser <= req.func;
        s_axis_tlast <= req.ends;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(req);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                       : $urandom_range(0, 10);
        end
    endtask

    // Holds the sender off until every expected result has arrived.
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_deliveries.size() != 0);
    endtask

    // Result side: check accepted results and stall on a changing pattern.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_delivery(delivery_t'({m_axis_tuser, m_axis_tdata[7:0], m_axis_tlast,
                                           m_axis_tdata[8], m_axis_tdata[15:9],
                                           m_axis_tdata[79:16]}));
        if (rx_left == 0)
        begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(20, 200);
        end
        else
            rx_left <= rx_left - 1;
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= (rx_tick % 4 == 0);
            default: m_axis_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[tcp_byte_stream_reassembler] ERROR");
            $finish;
        end
    end

    initial
    begin
        int                 issued;
        int unsigned        room;
        int                 seg_len;
        int                 pick;
        int                 j;
        int                 tmp;
        int                 order[$];
        logic [INDEX_W-1:0] base;
        logic [INDEX_W-1:0] index;

        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: unused kind, duplicates, window edges, end marks and consume limits.
        send_request(make_req(FUNC_UNUSED, '1, 8'hFF, 1'b1, 7'h7F));
        send_request(make_req(FUNC_DATA, 64'd0, 8'hFF, 1'b0, 7'd0));
        send_request(make_req(FUNC_DATA, 64'd0, 8'h00, 1'b0, 7'd0));
        send_request(make_req(FUNC_DATA, 64'd2, 8'h00, 1'b0, 7'd0));
        send_request(make_req(FUNC_DATA, 64'd2, 8'h55, 1'b0, 7'd0));
        send_request(make_req(FUNC_DATA, 64'd1, 8'hA5, 1'b0, 7'd0));
        send_request(make_req(FUNC_DATA, '1, 8'h3C, 1'b1, 7'd0));
        send_request(make_req(FUNC_END, 64'd7, 8'h00, 1'b0, 7'd0));
        send_request(make_req(FUNC_END, 64'd5, 8'h00, 1'b0, 7'd0));
        send_request(make_req(FUNC_DATA, 64'd4, 8'h11, 1'b0, 7'd0));
        send_request(make_req(FUNC_DATA, 64'd3, 8'h22, 1'b0, 7'd0));
        send_request(make_req(FUNC_DATA, 64'hAAAA_AAAA_AAAA_AAAA, 8'hAA, 1'b0, 7'h2A));
        send_request(make_req(FUNC_DATA, 64'h5555_5555_5555_5555, 8'h55, 1'b0, 7'h55));
        send_request(make_req(FUNC_DATA, 64'd64, 8'h01, 1'b0, 7'd0));
        send_request(make_req(FUNC_DATA, 64'd63, 8'h02, 1'b0, 7'd0));
        send_request(make_req(FUNC_CONSUME, 64'd0, 8'h00, 1'b0, 7'd127));
        send_request(make_req(FUNC_CONSUME, 64'd0, 8'h00, 1'b0, 7'd0));
        send_request(make_req(FUNC_CONSUME, 64'd0, 8'h00, 1'b0, 7'd64));
        send_request(make_req(FUNC_END, 64'd0, 8'h00, 1'b0, 7'd0));
        send_request(make_req(FUNC_DATA, 64'd5, 8'h80, 1'b0, 7'd0));
        wait_for_drain();

        // Random: mostly segments shuffled within the window, plus consumes,
        // end marks and stray requests.
        issued = 0;
        while (issued < RANDOM_REQUESTS)
        begin
            pick = $urandom_range(0, 9);
            room = sb.window_room();
            if (pick <= 4 && room >= 4)
            begin
                seg_len = ($urandom_range(0, 5) == 0) ? room
                        : $urandom_range(1, (room < 12) ? room : 12);
                order.delete();
                for (int k = 0; k < seg_len; k++)
                    order = {order, (seg_len == room) ? seg_len - 1 - k : k};
                // A full window goes in reverse so one byte releases all of it.
                if (seg_len != room)
                begin
                    for (int k = seg_len - 1; k > 0; k--)
                    begin
                        j = $urandom_range(0, k);
                        tmp = order[k];
                        order[k] = order[j];
                        order[j] = tmp;
                    end
                end
                base = sb.next_index;
                foreach (order[k])
                begin
                    send_request(make_req(FUNC_DATA, base + INDEX_W'(order[k]),
                                          BYTE_W'($urandom_range(0, 255)),
                                          order[k] == seg_len - 1 && $urandom_range(0, 3) == 0,
                                          CONSUMED_W'($urandom_range(0, 127))));
                    issued++;
                    if ($urandom_range(0, 9) == 0)
                    begin
                        send_request(make_req(FUNC_DATA,
                                              base + INDEX_W'(order[$urandom_range(0, k)]),
                                              BYTE_W'($urandom_range(0, 255)), 1'b0, 7'd0));
                        issued++;
                    end
                    if ($urandom_range(0, 14) == 0)
                    begin
                        send_request(make_req(FUNC_DATA,
                                              sb.next_index + INDEX_W'(sb.window_room())
                                              + INDEX_W'($urandom_range(0, 3)),
                                              BYTE_W'($urandom_range(0, 255)), 1'b0, 7'd0));
                        issued++;
                    end
                end
            end
            else if (pick <= 7 || room < 4)
            begin
                send_request(make_req(FUNC_CONSUME, INDEX_W'($urandom_range(0, 15)),
                                      BYTE_W'($urandom_range(0, 255)),
                                      1'($urandom_range(0, 1)),
                                      ($urandom_range(0, 4) == 0)
                                      ? CONSUMED_W'($urandom_range(0, 127))
                                      : CONSUMED_W'($urandom_range(0, sb.buffered_bytes))));
                issued++;
            end
            else if (pick == 8)
            begin
                send_request(make_req(FUNC_END,
                                      sb.next_index + INDEX_W'($urandom_range(0, 6)),
                                      BYTE_W'($urandom_range(0, 255)),
                                      1'($urandom_range(0, 1)), 7'd0));
                issued++;
            end
            else
            begin
                // Stray requests: far-off or stale indexes and the unused kind.
                index = {$urandom, $urandom};
                if ($urandom_range(0, 2) == 0 && sb.next_index >= 64'd8)
                    index = sb.next_index - INDEX_W'($urandom_range(1, 8));
                send_request(make_req(($urandom_range(0, 1) == 0) ? FUNC_DATA : FUNC_UNUSED,
                                      index, BYTE_W'($urandom_range(0, 255)),
                                      1'($urandom_range(0, 1)),
                                      CONSUMED_W'($urandom_range(0, 127))));
                issued++;
            end
            if ($urandom_range(0, 19) == 0)
                wait_for_drain();
        end

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_deliveries.size() == 0)
            $display("[tcp_byte_stream_reassembler] OK");
        else
            $display("[tcp_byte_stream_reassembler] ERROR");
        $finish;
    end

endmodule
